// ===== rtl/core/gyi_pkg.sv =====
// gyi_pkg: widths, codes, reset values and shared types of the yaw integrator
// no dependencies; imported by every module under rtl/core
package gyi_pkg;

  localparam int RAW_W      = 16;
  localparam int DT_W       = 16;
  localparam int CAL_W      = 13;
  localparam int TAU_W      = 24;
  localparam int DBAND_W    = 23;
  localparam int RATE_W     = 25;
  localparam int ANGLE_W    = 25;
  localparam int CNT_W      = 32;
  localparam int BIAS_W     = 25;
  localparam int FILT_W     = 26;
  localparam int SUM_W      = 28;
  localparam int DIFF_W     = 27;
  localparam int MUL_W      = 44;
  localparam int DEN_W      = 25;
  localparam int QUO_W      = 27;
  localparam int ASUM_W     = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int DIV_STEPS  = MUL_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CAL_W-1:0] CAL_MAX         = 13'd4096;
  localparam logic [CAL_W-1:0] CAL_MIN         = 13'd1;
  localparam logic [CAL_W-1:0] CAL_SAMPLES_RST = 13'd1000;
  localparam logic [TAU_W-1:0] TAU_RST         = 24'd79577;

  localparam logic [DEN_W-1:0]         ANGLE_DIVISOR   = 25'd256000;
  localparam logic signed [ASUM_W-1:0] ANGLE_HALF_TURN = 26'sd11796480;
  localparam logic signed [ASUM_W-1:0] ANGLE_FULL_TURN = 26'sd23592960;

  typedef enum logic [1:0] {
    FUNC_CAL,
    FUNC_UPDATE,
    FUNC_RESET_YAW,
    FUNC_READ_FAIL
  } func_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_DT_ZERO,
    ST_UNCAL
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_SAMPLES,
    CFG_FILTER_TAU,
    CFG_DEADBAND,
    CFG_YAW_NEGATE
  } cfg_reg_t;

  typedef struct packed {
    logic [CAL_W-1:0]   cal_target;
    logic [TAU_W-1:0]   tau;
    logic [DBAND_W-1:0] deadband;
    logic               yaw_negate;
  } cfg_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_SIGN
  } div_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_BSTART,
    S_BWAIT,
    S_DIFF,
    S_FMUL,
    S_FSTART,
    S_FWAIT,
    S_DBAND,
    S_AMUL,
    S_ASTART,
    S_AWAIT,
    S_WRAP,
    S_DONE
  } seq_state_t;

endpackage

// ===== rtl/core/gyro_yaw_integrator.sv =====
// gyro_yaw_integrator: top level, sequencer and state of the yaw gyro integrator
// depends on gyi_pkg, gyi_cfg_regs and gyi_divider
//
// One item is taken at a time; in_stall stays high until its result beat sits in the output
// register, and the next item may be taken while that beat still waits for the sink. A
// calibration sample that does not complete the bias, a yaw reset, a read failure and any
// rejected update go from S_EXEC straight to S_DONE. The calibration sample that completes
// the bias needs one pass and an accepted update two passes (filter step, angle step)
// through the shared divider, which resolves one of its 44 quotient bits per cycle. The
// multiplications share one 27 x 17 bit multiplier. Configuration writes are always taken
// and must only be made while the block is idle.
module gyro_yaw_integrator import gyi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                func,
  input  logic signed [RAW_W-1:0]   raw_rate,
  input  logic [DT_W-1:0]           dt_us,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic signed [RATE_W-1:0]  turn_rate,
  output logic signed [ANGLE_W-1:0] yaw_angle,
  output logic [CNT_W-1:0]          sample_total,
  output logic [CNT_W-1:0]          error_total,
  output logic                      calibrated
);

  cfg_t cfg;

  seq_state_t               state, state_next;
  func_t                    func_q, func_q_next;
  logic signed [RAW_W-1:0]  raw_q, raw_q_next;
  logic [DT_W-1:0]          dt_q, dt_q_next;
  status_t                  status_q, status_q_next;
  logic signed [BIAS_W-1:0] rate_bias, rate_bias_next;
  logic signed [SUM_W-1:0]  cal_sum, cal_sum_next;
  logic [CAL_W-1:0]         cal_count, cal_count_next;
  logic                     bias_ready, bias_ready_next;
  logic signed [FILT_W-1:0] filtered, filtered_next;
  logic signed [FILT_W-1:0] out_rate, out_rate_next;
  logic signed [ANGLE_W-1:0] angle, angle_next;
  logic [CNT_W-1:0]         upd_cnt, upd_cnt_next;
  logic [CNT_W-1:0]         fail_cnt, fail_cnt_next;
  logic signed [DIFF_W-1:0] diff_q, diff_q_next;
  logic signed [MUL_W-1:0]  prod, prod_next;
  logic [DEN_W-1:0]         den_q, den_q_next;
  logic signed [ASUM_W-1:0] angle_sum, angle_sum_next;
  logic                     out_valid_next;
  logic                     out_load;

  logic                     div_start;
  logic                     div_done;
  logic signed [MUL_W-1:0]  div_quo;

  logic signed [SUM_W-1:0]  cal_sum_inc;
  logic [CAL_W-1:0]         cal_count_inc;
  logic signed [DIFF_W-1:0] raw_sh;
  logic signed [DIFF_W-1:0] bias_ext;
  logic signed [DIFF_W-1:0] rate_val;
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [DT_W:0]     mul_b;
  logic signed [MUL_W-1:0]  mul_full;
  logic signed [QUO_W-1:0]  div_q_narrow;
  logic [FILT_W-1:0]        filt_mag;
  logic                     in_band;

  gyi_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gyi_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (prod),
    .den      (den_q),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rate_bias    <= '0;
      cal_sum      <= '0;
      cal_count    <= '0;
      bias_ready   <= 1'b0;
      filtered     <= '0;
      out_rate     <= '0;
      angle        <= '0;
      upd_cnt      <= '0;
      fail_cnt     <= '0;
      out_valid    <= 1'b0;
      status       <= ST_OK;
      turn_rate    <= '0;
      yaw_angle    <= '0;
      sample_total <= '0;
      error_total  <= '0;
      calibrated   <= 1'b0;
    end else begin
      state      <= state_next;
      rate_bias  <= rate_bias_next;
      cal_sum    <= cal_sum_next;
      cal_count  <= cal_count_next;
      bias_ready <= bias_ready_next;
      filtered   <= filtered_next;
      out_rate   <= out_rate_next;
      angle      <= angle_next;
      upd_cnt    <= upd_cnt_next;
      fail_cnt   <= fail_cnt_next;
      out_valid  <= out_valid_next;
      if (out_load) begin
        status       <= status_q;
        turn_rate    <= out_rate[RATE_W-1:0];
        yaw_angle    <= angle;
        sample_total <= upd_cnt;
        error_total  <= fail_cnt;
        calibrated   <= bias_ready;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_q    <= func_q_next;
    raw_q     <= raw_q_next;
    dt_q      <= dt_q_next;
    status_q  <= status_q_next;
    diff_q    <= diff_q_next;
    prod      <= prod_next;
    den_q     <= den_q_next;
    angle_sum <= angle_sum_next;
  end

  // datapath around the shared units
  always_comb begin
    cal_sum_inc   = cal_sum + SUM_W'(raw_q);
    cal_count_inc = cal_count + 1'b1;
    raw_sh        = $signed({{(DIFF_W-RAW_W-8){raw_q[RAW_W-1]}}, raw_q, 8'b0});
    bias_ext      = DIFF_W'(rate_bias);
    rate_val      = cfg.yaw_negate ? (bias_ext - raw_sh) : (raw_sh - bias_ext);
    mul_a         = (state == S_FMUL) ? diff_q : DIFF_W'(out_rate);
    mul_b         = $signed({1'b0, dt_q});
    mul_full      = mul_a * mul_b;
    div_q_narrow  = $signed(div_quo[QUO_W-1:0]);
    filt_mag      = filtered[FILT_W-1] ? FILT_W'(-filtered) : FILT_W'(filtered);
    in_band       = filt_mag < FILT_W'(cfg.deadband);
  end

  always_comb begin
    state_next      = state;
    func_q_next     = func_q;
    raw_q_next      = raw_q;
    dt_q_next       = dt_q;
    status_q_next   = status_q;
    rate_bias_next  = rate_bias;
    cal_sum_next    = cal_sum;
    cal_count_next  = cal_count;
    bias_ready_next = bias_ready;
    filtered_next   = filtered;
    out_rate_next   = out_rate;
    angle_next      = angle;
    upd_cnt_next    = upd_cnt;
    fail_cnt_next   = fail_cnt;
    diff_q_next     = diff_q;
    prod_next       = prod;
    den_q_next      = den_q;
    angle_sum_next  = angle_sum;
    div_start       = 1'b0;
    out_load        = 1'b0;
    out_valid_next  = out_valid && out_stall;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          func_q_next = func_t'(func);
          raw_q_next  = raw_rate;
          dt_q_next   = dt_us;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        status_q_next = ST_OK;
        state_next    = S_DONE;
        case (func_q)
          FUNC_CAL: begin
            if (!bias_ready) begin
              cal_sum_next   = cal_sum_inc;
              cal_count_next = cal_count_inc;
              if (cal_count_inc >= cfg.cal_target) begin
                prod_next  = MUL_W'(cal_sum_inc) <<< 8;
                den_q_next = DEN_W'(cal_count_inc);
                state_next = S_BSTART;
              end
            end
          end
          FUNC_RESET_YAW: begin
            filtered_next = '0;
            out_rate_next = '0;
            angle_next    = '0;
          end
          default: begin
            if (!bias_ready) begin
              status_q_next = ST_UNCAL;
            end else if (dt_q == '0) begin
              status_q_next = ST_DT_ZERO;
            end else if (func_q == FUNC_READ_FAIL) begin
              if (fail_cnt != '1) begin
                fail_cnt_next = fail_cnt + 1'b1;
              end
            end else begin
              diff_q_next = rate_val;
              state_next  = S_DIFF;
            end
          end
        endcase
      end
      S_BSTART: begin
        div_start  = 1'b1;
        state_next = S_BWAIT;
      end
      S_BWAIT: begin
        if (div_done) begin
          rate_bias_next  = div_quo[BIAS_W-1:0];
          bias_ready_next = 1'b1;
          state_next      = S_DONE;
        end
      end
      S_DIFF: begin
        diff_q_next = diff_q - DIFF_W'(filtered);
        state_next  = S_FMUL;
      end
      S_FMUL: begin
        prod_next  = mul_full;
        den_q_next = DEN_W'(cfg.tau) + DEN_W'(dt_q);
        state_next = S_FSTART;
      end
      S_FSTART: begin
        div_start  = 1'b1;
        state_next = S_FWAIT;
      end
      S_FWAIT: begin
        if (div_done) begin
          filtered_next = FILT_W'(DIFF_W'(filtered) + div_q_narrow);
          state_next    = S_DBAND;
        end
      end
      S_DBAND: begin
        out_rate_next = in_band ? '0 : filtered;
        state_next    = S_AMUL;
      end
      S_AMUL: begin
        prod_next  = mul_full;
        den_q_next = ANGLE_DIVISOR;
        state_next = S_ASTART;
      end
      S_ASTART: begin
        div_start  = 1'b1;
        state_next = S_AWAIT;
      end
      S_AWAIT: begin
        if (div_done) begin
          angle_sum_next = ASUM_W'(angle) + $signed(div_quo[ASUM_W-1:0]);
          state_next     = S_WRAP;
        end
      end
      S_WRAP: begin
        if (angle_sum > ANGLE_HALF_TURN) begin
          angle_next = ANGLE_W'(angle_sum - ANGLE_FULL_TURN);
        end else if (angle_sum <= -ANGLE_HALF_TURN) begin
          angle_next = ANGLE_W'(angle_sum + ANGLE_FULL_TURN);
        end else begin
          angle_next = ANGLE_W'(angle_sum);
        end
        if (upd_cnt != '1) begin
          upd_cnt_next = upd_cnt + 1'b1;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/gyi_cfg_regs.sv =====
// gyi_cfg_regs: configuration register file with calibration count clamping
// depends on gyi_pkg
module gyi_cfg_regs import gyi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [CAL_W-1:0]   cal_samples;
  logic [TAU_W-1:0]   tau;
  logic [DBAND_W-1:0] deadband;
  logic               yaw_negate;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_samples <= CAL_SAMPLES_RST;
      tau         <= TAU_RST;
      deadband    <= '0;
      yaw_negate  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CAL_SAMPLES: cal_samples <= cfg_data[CAL_W-1:0];
        CFG_FILTER_TAU:  tau         <= cfg_data[TAU_W-1:0];
        CFG_DEADBAND:    deadband    <= cfg_data[DBAND_W-1:0];
        CFG_YAW_NEGATE:  yaw_negate  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.tau        = tau;
    cfg.deadband   = deadband;
    cfg.yaw_negate = yaw_negate;
    if (cal_samples == '0) begin
      cfg.cal_target = CAL_MIN;
    end else if (cal_samples > CAL_MAX) begin
      cfg.cal_target = CAL_MAX;
    end else begin
      cfg.cal_target = cal_samples;
    end
  end

endmodule

// ===== rtl/core/gyi_divider.sv =====
// gyi_divider: shared signed divider, one quotient bit per cycle, rounds half away from zero
// depends on gyi_pkg
module gyi_divider import gyi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [MUL_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [MUL_W-1:0] quotient
);

  div_state_t             state, state_next;
  logic [MUL_W-1:0]       quo, quo_next;
  logic [DEN_W-1:0]       rem, rem_next;
  logic [DEN_W-1:0]       den_r, den_r_next;
  logic                   neg, neg_next;
  logic [DIV_CNT_W-1:0]   step, step_next;
  logic                   done_next;
  logic signed [MUL_W-1:0] quotient_next;

  logic [MUL_W-1:0] mag;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    quo      <= quo_next;
    rem      <= rem_next;
    den_r    <= den_r_next;
    neg      <= neg_next;
    step     <= step_next;
    quotient <= quotient_next;
  end

  always_comb begin
    mag     = num[MUL_W-1] ? (~num + 1'b1) : num;
    shifted = {rem, quo[MUL_W-1]};
    trial   = shifted - {1'b0, den_r};
    fits    = !trial[DEN_W];

    state_next    = state;
    quo_next      = quo;
    rem_next      = rem;
    den_r_next    = den_r;
    neg_next      = neg;
    step_next     = step;
    done_next     = 1'b0;
    quotient_next = quotient;

    case (state)
      DIV_IDLE: begin
        if (start) begin
          quo_next   = mag + MUL_W'(den >> 1);
          rem_next   = '0;
          den_r_next = den;
          neg_next   = num[MUL_W-1];
          step_next  = '0;
          state_next = DIV_RUN;
        end
      end
      DIV_RUN: begin
        rem_next  = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo_next  = {quo[MUL_W-2:0], fits};
        step_next = step + 1'b1;
        if (step == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = DIV_SIGN;
        end
      end
      DIV_SIGN: begin
        quotient_next = neg ? -$signed(quo) : $signed(quo);
        done_next     = 1'b1;
        state_next    = DIV_IDLE;
      end
      default: state_next = DIV_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/gyi_checker.sv =====
// gyi_checker: port level checks on the yaw integrator, bound to the top level
// depends on gyi_pkg and gyro_yaw_integrator
module gyi_checker import gyi_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                status,
  input logic signed [ANGLE_W-1:0] yaw_angle,
  input logic [CNT_W-1:0]          sample_total,
  input logic                      calibrated
);

  // a held result beat keeps its status, angle and update count
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(yaw_angle) && $stable(sample_total)
      && $stable(status))
    else $error("result beat changed while stalled");

  // only one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // angle stays within one turn
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (yaw_angle > -ANGLE_HALF_TURN) && (yaw_angle <= ANGLE_HALF_TURN))
    else $error("yaw angle outside (-180,180]");

  // bias, once complete, is kept
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> !$fell(calibrated))
    else $error("calibrated flag dropped");

  // update count never goes back
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> sample_total >= $past(sample_total))
    else $error("sample total decreased");

endmodule

bind gyro_yaw_integrator gyi_checker u_gyi_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .yaw_angle    (yaw_angle),
  .sample_total (sample_total),
  .calibrated   (calibrated)
);

// ===== dv/gyro_yaw_integrator_tb.sv =====
// gyro_yaw_integrator_tb: self-checking testbench for the yaw gyro integrator
// a directed table, then random phases of item beats under varied idling, each result checked
// depends on gyi_pkg and gyro_yaw_integrator
module gyro_yaw_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gyi_pkg::*;

  typedef struct packed {
    status_t                    status;
    logic signed [RATE_W-1:0]   rate;
    logic signed [ANGLE_W-1:0]  angle;
    logic [CNT_W-1:0]           samples;
    logic [CNT_W-1:0]           errors;
    logic                       cal;
  } yaw_beat_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TYPED,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    cfg_reg_t                 reg_idx;
    logic [CFG_DATA_W-1:0]    reg_val;
    func_t                    fn;
    logic signed [RAW_W-1:0]  raw;
    logic [DT_W-1:0]          dt;
    yaw_beat_t                want;
  } step_row_t;

  localparam yaw_beat_t UNCAL_ZERO = '{ST_UNCAL, '0, '0, '0, '0, 1'b0};
  localparam yaw_beat_t IDLE_ZERO  = '{ST_OK, '0, '0, '0, '0, 1'b0};
  localparam yaw_beat_t BIAS_SET   = '{ST_OK, '0, '0, '0, '0, 1'b1};
  localparam yaw_beat_t DT_REJECT  = '{ST_DT_ZERO, '0, '0, '0, '0, 1'b1};

  localparam int N_ROWS = 30;
  localparam step_row_t STEP_ROWS [N_ROWS] = '{
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_UPDATE,    16'sd100,   16'd1000,  UNCAL_ZERO},
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_READ_FAIL, 16'sd0,     16'd7,     UNCAL_ZERO},
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_UPDATE,    -16'sd5,    16'd0,     UNCAL_ZERO},
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_RESET_YAW, 16'sd0,     16'd0,     IDLE_ZERO},
    '{ROW_REG,     CFG_CAL_SAMPLES, 24'hFFFFFF, FUNC_CAL,  16'sd0,     16'd0,     IDLE_ZERO},
    '{ROW_REG,     CFG_FILTER_TAU,  24'd1,      FUNC_CAL,  16'sd0,     16'd0,     IDLE_ZERO},
    '{ROW_REG,     CFG_DEADBAND,    24'h800000, FUNC_CAL,  16'sd0,     16'd0,     IDLE_ZERO},
    '{ROW_REG,     CFG_YAW_NEGATE,  24'hFFFFFE, FUNC_CAL,  16'sd0,     16'd0,     IDLE_ZERO},
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_CAL,       16'sd32767, 16'd0,     IDLE_ZERO},
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_CAL,       16'sh8000,  16'd65535, IDLE_ZERO},
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_CAL,       -16'sd1,    16'd1,     IDLE_ZERO},
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_CAL,       16'sd0,     16'd65535, IDLE_ZERO},
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_CAL,       16'sd12345, 16'd0,     IDLE_ZERO},
    '{ROW_REG,     CFG_CAL_SAMPLES, 24'd0,      FUNC_CAL,  16'sd0,     16'd0,     IDLE_ZERO},
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_CAL,       16'sd300,   16'd0,     BIAS_SET},
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_CAL,       16'sh8000,  16'd9,     BIAS_SET},
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_UPDATE,    16'sd32767, 16'd0,     DT_REJECT},
    '{ROW_TYPED,   CFG_CAL_SAMPLES, 24'd0, FUNC_READ_FAIL, 16'sd1,     16'd0,     DT_REJECT},
    '{ROW_PREDICT, CFG_CAL_SAMPLES, 24'd0, FUNC_READ_FAIL, 16'sd0,     16'd1,     IDLE_ZERO},
    '{ROW_PREDICT, CFG_CAL_SAMPLES, 24'd0, FUNC_UPDATE,    16'sd32767, 16'd65535, IDLE_ZERO},
    '{ROW_PREDICT, CFG_CAL_SAMPLES, 24'd0, FUNC_UPDATE,    16'sd32767, 16'd65535, IDLE_ZERO},
    '{ROW_PREDICT, CFG_CAL_SAMPLES, 24'd0, FUNC_UPDATE,    16'sd32767, 16'd65535, IDLE_ZERO},
    '{ROW_PREDICT, CFG_CAL_SAMPLES, 24'd0, FUNC_UPDATE,    16'sh8000,  16'd1,     IDLE_ZERO},
    '{ROW_REG,     CFG_YAW_NEGATE,  24'd1,      FUNC_CAL,  16'sd0,     16'd0,     IDLE_ZERO},
    '{ROW_PREDICT, CFG_CAL_SAMPLES, 24'd0, FUNC_UPDATE,    16'sh8000,  16'd65535, IDLE_ZERO},
    '{ROW_REG,     CFG_DEADBAND,    24'h7FFFFF, FUNC_CAL,  16'sd0,     16'd0,     IDLE_ZERO},
    '{ROW_PREDICT, CFG_CAL_SAMPLES, 24'd0, FUNC_UPDATE,    16'sd0,     16'd1000,  IDLE_ZERO},
    '{ROW_REG,     CFG_FILTER_TAU,  24'hFFFFFF, FUNC_CAL,  16'sd0,     16'd0,     IDLE_ZERO},
    '{ROW_PREDICT, CFG_CAL_SAMPLES, 24'd0, FUNC_UPDATE,    16'sd32767, 16'd65535, IDLE_ZERO},
    '{ROW_PREDICT, CFG_CAL_SAMPLES, 24'd0, FUNC_RESET_YAW, 16'sd77,    16'd3,     IDLE_ZERO}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  cfg_reg_t                 cfg_index = CFG_CAL_SAMPLES;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  func_t                    func = FUNC_CAL;
  logic signed [RAW_W-1:0]  raw_rate = '0;
  logic [DT_W-1:0]          dt_us = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic signed [RATE_W-1:0] turn_rate;
  logic signed [ANGLE_W-1:0] yaw_angle;
  logic [CNT_W-1:0]         sample_total;
  logic [CNT_W-1:0]         error_total;
  logic                     calibrated;

  // predictor state and register copies
  logic [CAL_W-1:0]   cal_target_r = CAL_SAMPLES_RST;
  logic [TAU_W-1:0]   tau_r = TAU_RST;
  logic [DBAND_W-1:0] dband_r = '0;
  logic               negate_r = 1'b0;
  longint             bias_q8 = 0;
  longint             cal_acc = 0;
  longint             cal_seen = 0;
  logic               bias_done = 1'b0;
  longint             lpf_rate = 0;
  longint             out_rate = 0;
  longint             yaw_acc = 0;
  logic [CNT_W-1:0]   ok_updates = '0;
  logic [CNT_W-1:0]   fail_reads = '0;

  yaw_beat_t due_reports[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off_req = 0;
  int hold_left = 0;
  int fault_count = 0;
  int beats_checked = 0;
  int items_sent = 0;
  int reg_writes = 0;
  int wrap_count = 0;

  gyro_yaw_integrator i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .raw_rate     (raw_rate),
    .dt_us        (dt_us),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .turn_rate    (turn_rate),
    .yaw_angle    (yaw_angle),
    .sample_total (sample_total),
    .error_total  (error_total),
    .calibrated   (calibrated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  task automatic advance_yaw(input func_t fn, input logic signed [RAW_W-1:0] raw,
                             input logic [DT_W-1:0] dt, output yaw_beat_t beat);
    longint  rate;
    longint  mag;
    longint  span;
    longint  need;
    status_t st;
    st = ST_OK;
    span = longint'(dt);
    case (fn)
      FUNC_CAL: begin
        if (!bias_done) begin
          need = longint'(cal_target_r);
          if (need == 0) need = 1;
          if (need > longint'(CAL_MAX)) need = longint'(CAL_MAX);
          cal_acc += longint'(raw);
          cal_seen++;
          if (cal_seen >= need) begin
            bias_q8 = round_div(cal_acc * 256, cal_seen);
            bias_done = 1'b1;
          end
        end
      end
      FUNC_RESET_YAW: begin
        lpf_rate = 0;
        out_rate = 0;
        yaw_acc = 0;
      end
      default: begin
        if (!bias_done) begin
          st = ST_UNCAL;
        end else if (dt == 0) begin
          st = ST_DT_ZERO;
        end else if (fn == FUNC_READ_FAIL) begin
          if (fail_reads != '1) fail_reads++;
        end else begin
          rate = longint'(raw) * 256 - bias_q8;
          if (negate_r) rate = -rate;
          lpf_rate += round_div(span * (rate - lpf_rate), longint'(tau_r) + span);
          mag = (lpf_rate < 0) ? -lpf_rate : lpf_rate;
          out_rate = (mag < longint'(dband_r)) ? 0 : lpf_rate;
          yaw_acc += round_div(out_rate * span, longint'(ANGLE_DIVISOR));
          if (yaw_acc > longint'(ANGLE_HALF_TURN)) begin
            yaw_acc -= longint'(ANGLE_FULL_TURN);
            wrap_count++;
          end else if (yaw_acc <= -longint'(ANGLE_HALF_TURN)) begin
            yaw_acc += longint'(ANGLE_FULL_TURN);
            wrap_count++;
          end
          if (ok_updates != '1) ok_updates++;
        end
      end
    endcase
    beat.status  = st;
    beat.rate    = out_rate[RATE_W-1:0];
    beat.angle   = yaw_acc[ANGLE_W-1:0];
    beat.samples = ok_updates;
    beat.errors  = fail_reads;
    beat.cal     = bias_done;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CAL_SAMPLES: cal_target_r = val[CAL_W-1:0];
      CFG_FILTER_TAU:  tau_r = val[TAU_W-1:0];
      CFG_DEADBAND:    dband_r = val[DBAND_W-1:0];
      CFG_YAW_NEGATE:  negate_r = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic offer_item(func_t fn, logic signed [RAW_W-1:0] raw, logic [DT_W-1:0] dt,
                            bit typed, yaw_beat_t want);
    yaw_beat_t beat;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    raw_rate <= raw;
    dt_us <= dt;
    do @(posedge clk); while (in_stall);
    advance_yaw(fn, raw, dt, beat);
    due_reports.push_back(typed ? want : beat);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_fault(string why, yaw_beat_t want, yaw_beat_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t %s: want st=%0d rate=%0d angle=%0d n=%0d err=%0d cal=%0d,", $realtime,
               why, want.status, want.rate, want.angle, want.samples, want.errors, want.cal,
               " got st=%0d rate=%0d angle=%0d n=%0d err=%0d cal=%0d", got.status, got.rate,
               got.angle, got.samples, got.errors, got.cal);
  endtask

  // result side: check accepted beats, then choose the stall for the next cycle
  initial begin
    yaw_beat_t got;
    yaw_beat_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.status  = status_t'(status);
        got.rate    = turn_rate;
        got.angle   = yaw_angle;
        got.samples = sample_total;
        got.errors  = error_total;
        got.cal     = calibrated;
        beats_checked++;
        if (due_reports.size() == 0) begin
          report_fault("unexpected beat", IDLE_ZERO, got);
        end else begin
          want = due_reports.pop_front();
          if (got !== want) report_fault("mismatch", want, got);
        end
      end
      if (hold_off_req != 0) begin
        hold_off_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int                      counted;
    int                      centre;
    int                      jitter;
    int                      v;
    int                      pick;
    bit                      paused;
    func_t                   fn;
    logic signed [RAW_W-1:0] raw;
    logic [DT_W-1:0]         dt;
    logic [CFG_DATA_W-1:0]   data;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (STEP_ROWS[i]) begin
      if (STEP_ROWS[i].kind == ROW_REG) begin
        if (i == 0 || STEP_ROWS[i-1].kind != ROW_REG) settle();
        write_reg(STEP_ROWS[i].reg_idx, STEP_ROWS[i].reg_val);
      end else begin
        offer_item(STEP_ROWS[i].fn, STEP_ROWS[i].raw, STEP_ROWS[i].dt,
                   STEP_ROWS[i].kind == ROW_TYPED, STEP_ROWS[i].want);
      end
    end

    paused = 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase

      data = 24'($urandom);
      data[CAL_W-1:0] = (ph == 0) ? '0 : (ph == 1) ? '1 : CAL_W'($urandom);
      write_reg(CFG_CAL_SAMPLES, data);

      case ($urandom_range(3))
        0: data = 24'd1;
        1: data = 24'hFFFFFF;
        2: data = 24'($urandom_range(1, 100000));
        default: data = 24'($urandom_range(1, 24'hFFFFFF));
      endcase
      if (ph == 0) data = 24'd1;
      if (ph == 1) data = 24'hFFFFFF;
      write_reg(CFG_FILTER_TAU, data);

      data = 24'($urandom);
      case ($urandom_range(3))
        0: data[DBAND_W-1:0] = '0;
        1: data[DBAND_W-1:0] = '1;
        2: data[DBAND_W-1:0] = DBAND_W'($urandom_range(0, 1 << 20));
        default: ;
      endcase
      if (ph == 0) data[DBAND_W-1:0] = '0;
      if (ph == 1) data[DBAND_W-1:0] = '1;
      write_reg(CFG_DEADBAND, data);

      data = 24'($urandom);
      if (ph < 2) data[0] = ph[0];
      write_reg(CFG_YAW_NEGATE, data);

      // a steady turn with jitter, so the angle wraps now and then
      centre = int'($urandom_range(0, 65535)) - 32768;
      jitter = $urandom_range(0, 3000);
      if (ph == 0) hold_off_req = 1;

      counted = 0;
      while (counted < 85) begin
        if (ph == 6 && counted == 50 && !paused) begin
          paused = 1'b1;
          settle();
        end
        pick = $urandom_range(99);
        if (pick < 72) fn = FUNC_UPDATE;
        else if (pick < 76) fn = FUNC_RESET_YAW;
        else if (pick < 88) fn = FUNC_READ_FAIL;
        else fn = FUNC_CAL;

        if ($urandom_range(99) < 15) begin
          raw = RAW_W'($urandom);
        end else begin
          v = centre + int'($urandom_range(0, 2 * jitter)) - jitter;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          raw = RAW_W'(v);
        end

        pick = $urandom_range(99);
        if (pick < 4) dt = '0;
        else if (pick < 8) dt = '1;
        else if (pick < 12) dt = 16'd1;
        else if (pick < 55) dt = DT_W'($urandom_range(40000, 65535));
        else dt = DT_W'($urandom_range(1, 65535));

        offer_item(fn, raw, dt, 1'b0, IDLE_ZERO);
        if (fn != FUNC_CAL) counted++;
      end
    end

    settle();
    repeat (200) @(posedge clk);

    $display("%0d item beats and %0d register writes over 8 idling phases", items_sent,
             reg_writes);
    $display("%0d result beats compared, %0d angle wraps predicted, %0d faults", beats_checked,
             wrap_count, fault_count);
    if (fault_count == 0 && due_reports.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== gyro_yaw_integrator.f =====
rtl/core/gyi_pkg.sv
rtl/core/gyi_cfg_regs.sv
rtl/core/gyi_divider.sv
rtl/core/gyro_yaw_integrator.sv
rtl/core/gyi_checker.sv
dv/gyro_yaw_integrator_tb.sv
